[sv/gefa_pkg.sv]
// Shared types and constants for the graph edge-flip annealer.
package gefa_pkg;

  // Field widths and packing of the stream payloads
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int REQ_W      = 2;
  localparam int VTX_W      = 7;
  localparam int ROLL_W     = 10;
  localparam int BOOK_W     = 6;
  localparam int VC_W       = 11;

  localparam int VA_LSB   = 0;
  localparam int VB_LSB   = 7;
  localparam int ROLL_LSB = 14;
  localparam int THR_LSB  = 24;

  localparam logic [BOOK_W-1:0] BOOK_RESET = 6'd2;

  // Request codes carried in s_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_FORCE  = 2'd1,
    REQ_ANNEAL = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LATCH,
    OP_CLEAR,
    OP_RD0,
    OP_RD1,
    OP_CAP,
    OP_PAIR,
    OP_DA,
    OP_DB,
    OP_DECIDE,
    OP_UA,
    OP_UB,
    OP_WRA,
    OP_WRB
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ld_res;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic skip;
    logic k_last;
    logic clr_last;
    logic flip;
  } stat_t;

endpackage

[sv/gefa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gefa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/gefa_datapath.sv]
// Datapath: graph storage, violation delta accumulation and incremental count update.
module gefa_datapath #(
  parameter int MAX_VERTICES = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [gefa_pkg::BOOK_W-1:0]         cfg_wr_data,
  input  logic [gefa_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [gefa_pkg::REQ_W-1:0]          in_user,
  input  gefa_pkg::cmd_t                      cmd,
  output gefa_pkg::stat_t                     stat,
  output logic [gefa_pkg::OUT_DATA_W-1:0]     res_data
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int NVW  = VW + 1;
  localparam int XW   = VW + 4;
  localparam int AW   = (2 * VW + 4 > 12) ? 2 * VW + 4 : 12;
  localparam int PW   = 2 * VW;
  localparam int CMPW = (NVW > gefa_pkg::VTX_W) ? NVW : gefa_pkg::VTX_W;
  localparam int EW   = (VW + 2 > gefa_pkg::BOOK_W) ? VW + 2 : gefa_pkg::BOOK_W;
  localparam int N_HI = (MAX_VERTICES + 2) / 4;

  localparam logic [NVW-1:0]          MAXV   = NVW'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] BIT0   = MAX_VERTICES'(1);
  localparam logic signed [XW-1:0]    ONE_X  = XW'(1);
  localparam logic signed [XW-1:0]    TWO_X  = XW'(2);
  localparam logic signed [XW-1:0]    ZERO_X = XW'(0);
  localparam logic signed [AW-1:0]    ACC_ZERO = AW'(0);
  localparam logic signed [AW-1:0]    SAT_HI = AW'(1023);
  localparam logic signed [AW-1:0]    SAT_LO = AW'(-1024);

  // Amount by which v exceeds lim, else zero
  function automatic logic signed [XW-1:0] exc(input logic signed [XW-1:0] v,
                                               input logic signed [XW-1:0] lim);
    return (v > lim) ? v - lim : ZERO_X;
  endfunction

  function automatic logic signed [XW-1:0] sx(input logic [VW-1:0] v);
    return $signed(XW'(v));
  endfunction

  // Canonical address of an unordered vertex pair
  function automatic logic [PW-1:0] pair_addr(input logic [VW-1:0] x,
                                               input logic [VW-1:0] y);
    return (x < y) ? {x, y} : {y, x};
  endfunction

  // Change of the pair (x,k) violation when the edge (x,y) flips
  function automatic logic signed [XW-1:0] side_term(
    input logic [VW-1:0]        c,
    input logic [VW-1:0]        dx,
    input logic [VW-1:0]        dk,
    input logic                 adj_x,
    input logic                 adj_y,
    input logic                 add,
    input logic signed [XW-1:0] me,
    input logic signed [XW-1:0] mn,
    input logic signed [XW-1:0] vm2
  );
    logic signed [XW-1:0] cs, ncs, dxs, ndxs, dks, t;
    cs   = sx(c);
    dxs  = sx(dx);
    dks  = sx(dk);
    ndxs = add ? dxs + ONE_X : dxs - ONE_X;
    ncs  = adj_y ? (add ? cs + ONE_X : cs - ONE_X) : cs;
    if (adj_x) begin
      t = exc(ncs, me) - exc(cs, me);
    end else begin
      t = exc(vm2 - ndxs - dks + ncs, mn) - exc(vm2 - dxs - dks + cs, mn);
    end
    return t;
  endfunction

  logic [gefa_pkg::BOOK_W-1:0] book;
  logic [EW-1:0]               bk, n_c;
  logic [NVW-1:0]              nv;
  logic signed [XW-1:0]        me, mn, vm2;

  gefa_pkg::req_t              lreq;
  logic [gefa_pkg::VTX_W-1:0]  la, lb;
  logic [gefa_pkg::ROLL_W-1:0] lroll, lthr;
  logic [CMPW-1:0]             la_w, lb_w;
  logic [VW-1:0]               va, vb;

  logic [MAX_VERTICES-1:0] rowa, rowb;
  logic [VW-1:0]           da, db, cab, dk, k, pk;
  logic                    was, add;
  logic                    pend_a, pend_b, pw_a, pw_b;
  logic signed [AW-1:0]    acc;
  logic                    flip_r, flip_now;
  logic [PW-1:0]           clr;
  logic                    clr_lo_ok;
  logic                    pk_self;

  logic signed [XW-1:0]    term_a, term_b, pair_t;
  logic signed [XW-1:0]    cs_p, das, dbs, ndas, ndbs;
  logic [gefa_pkg::VC_W-1:0] vc;

  logic                    res_edge, res_skip, res_flip;
  logic [gefa_pkg::VC_W-1:0] res_vc;

  // RAM ports
  logic                    adj_we;
  logic [VW-1:0]           adj_wa, adj_ra;
  logic [MAX_VERTICES-1:0] adj_wd, adj_rd;
  logic                    deg_we;
  logic [VW-1:0]           deg_wa, deg_ra, deg_wd, deg_rd;
  logic                    com_we;
  logic [PW-1:0]           com_wa, com_ra;
  logic [VW-1:0]           com_wd, com_rd;

  // Book size register; a write while the controller is idle also triggers a clearing pass in the controller
  always_ff @(posedge clk) begin
    if (rst) begin
      book <= gefa_pkg::BOOK_RESET;
    end else if (cfg_wr_en) begin
      book <= cfg_wr_data;
    end
  end

  // Clamp book size and derive vertex count and limits
  always_comb begin
    bk = EW'(book);
    if (bk < EW'(2)) begin
      n_c = EW'(2);
    end else if (bk > EW'(N_HI)) begin
      n_c = EW'(N_HI);
    end else begin
      n_c = bk;
    end
    nv  = NVW'((n_c << 2) - EW'(2));
    me  = $signed(XW'(n_c)) - TWO_X;
    mn  = $signed(XW'(n_c)) - ONE_X;
    vm2 = $signed(XW'(nv)) - TWO_X;
  end

  // Latch the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.op == gefa_pkg::OP_LATCH) begin
      lreq  <= gefa_pkg::req_t'(in_user);
      la    <= in_data[gefa_pkg::VA_LSB +: gefa_pkg::VTX_W];
      lb    <= in_data[gefa_pkg::VB_LSB +: gefa_pkg::VTX_W];
      lroll <= in_data[gefa_pkg::ROLL_LSB +: gefa_pkg::ROLL_W];
      lthr  <= in_data[gefa_pkg::THR_LSB +: gefa_pkg::ROLL_W];
    end
  end

  assign la_w = CMPW'(la);
  assign lb_w = CMPW'(lb);
  assign va   = la_w[VW-1:0];
  assign vb   = lb_w[VW-1:0];
  assign add  = ~was;

  // Status toward the controller
  assign stat.is_clear = (lreq == gefa_pkg::REQ_CLEAR);
  assign stat.skip     = (lreq == gefa_pkg::REQ_CLEAR) || (lreq == gefa_pkg::REQ_NOP) ||
                         (la == lb) || (la_w >= CMPW'(nv)) || (lb_w >= CMPW'(nv));
  assign stat.k_last   = ({1'b0, k} == nv - NVW'(1));
  assign stat.clr_last = &clr;
  assign flip_now      = (lreq == gefa_pkg::REQ_FORCE) || (acc <= ACC_ZERO) || (lroll < lthr);
  assign stat.flip     = flip_now;

  assign clr_lo_ok = ({1'b0, clr[VW-1:0]} < MAXV);
  assign pk_self   = (pk == va) || (pk == vb);

  // Violation change of the pair itself
  always_comb begin
    cs_p = sx(cab);
    das  = sx(da);
    dbs  = sx(db);
    ndas = add ? das + ONE_X : das - ONE_X;
    ndbs = add ? dbs + ONE_X : dbs - ONE_X;
    if (was) begin
      pair_t = exc(vm2 - ndas - ndbs + cs_p, mn) - exc(cs_p, me);
    end else begin
      pair_t = exc(cs_p, me) - exc(vm2 - das - dbs + cs_p, mn);
    end
  end

  // Per-vertex terms on the data returning from the count RAM
  assign term_a = side_term(com_rd, da, deg_rd, rowa[pk], rowb[pk], add, me, mn, vm2);
  assign term_b = side_term(com_rd, db, dk, rowb[pk], rowa[pk], add, me, mn, vm2);

  // Sequencing registers: vertex walk, pending reads, clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      clr    <= '0;
      pend_a <= 1'b0;
      pend_b <= 1'b0;
      pw_a   <= 1'b0;
      pw_b   <= 1'b0;
    end else begin
      case (cmd.op)
        gefa_pkg::OP_DA, gefa_pkg::OP_UA: k <= k;
        gefa_pkg::OP_DB, gefa_pkg::OP_UB: k <= k + VW'(1);
        default:                          k <= '0;
      endcase
      clr    <= (cmd.op == gefa_pkg::OP_CLEAR) ? clr + PW'(1) : '0;
      pend_a <= (cmd.op == gefa_pkg::OP_DA);
      pend_b <= (cmd.op == gefa_pkg::OP_DB);
      pw_a   <= (cmd.op == gefa_pkg::OP_UA);
      pw_b   <= (cmd.op == gefa_pkg::OP_UB);
    end
  end

  // Capture rows, degrees and counts; accumulate the delta
  always_ff @(posedge clk) begin
    pk <= k;
    if (cmd.op == gefa_pkg::OP_RD1) begin
      rowa <= adj_rd;
      da   <= deg_rd;
      cab  <= com_rd;
    end
    if (cmd.op == gefa_pkg::OP_CAP) begin
      rowb <= adj_rd;
      db   <= deg_rd;
      was  <= rowa[vb];
    end
    if (pend_a) begin
      dk <= deg_rd;
    end
    if (cmd.op == gefa_pkg::OP_PAIR) begin
      acc <= AW'(pair_t);
    end else if (pend_a && !pk_self) begin
      acc <= acc + AW'(term_a);
    end else if (pend_b && !pk_self) begin
      acc <= acc + AW'(term_b);
    end
    if (cmd.op == gefa_pkg::OP_LATCH) begin
      flip_r <= 1'b0;
    end else if (cmd.op == gefa_pkg::OP_DECIDE) begin
      flip_r <= flip_now;
    end
  end

  // RAM read address selection
  always_comb begin
    adj_ra = (cmd.op == gefa_pkg::OP_RD1) ? vb : va;
    case (cmd.op)
      gefa_pkg::OP_RD1: deg_ra = vb;
      gefa_pkg::OP_DA:  deg_ra = k;
      default:          deg_ra = va;
    endcase
    case (cmd.op)
      gefa_pkg::OP_DA, gefa_pkg::OP_UA: com_ra = pair_addr(va, k);
      gefa_pkg::OP_DB, gefa_pkg::OP_UB: com_ra = pair_addr(vb, k);
      default:                          com_ra = pair_addr(va, vb);
    endcase
  end

  // RAM write selection: clear sweep, edge toggle, count bumps
  always_comb begin
    adj_we = 1'b0;
    adj_wa = va;
    adj_wd = '0;
    deg_we = 1'b0;
    deg_wa = va;
    deg_wd = '0;
    case (cmd.op)
      gefa_pkg::OP_CLEAR: begin
        adj_we = clr_lo_ok;
        adj_wa = clr[VW-1:0];
        deg_we = clr_lo_ok;
        deg_wa = clr[VW-1:0];
      end
      gefa_pkg::OP_WRA: begin
        adj_we = 1'b1;
        adj_wd = rowa ^ (BIT0 << vb);
        deg_we = 1'b1;
        deg_wd = add ? da + VW'(1) : da - VW'(1);
      end
      gefa_pkg::OP_WRB: begin
        adj_we = 1'b1;
        adj_wa = vb;
        adj_wd = rowb ^ (BIT0 << va);
        deg_we = 1'b1;
        deg_wa = vb;
        deg_wd = add ? db + VW'(1) : db - VW'(1);
      end
      default: begin
      end
    endcase

    com_we = 1'b0;
    com_wa = clr;
    com_wd = '0;
    if (cmd.op == gefa_pkg::OP_CLEAR) begin
      com_we = 1'b1;
    end else if (pw_a && (pk != va) && rowb[pk]) begin
      com_we = 1'b1;
      com_wa = pair_addr(va, pk);
      com_wd = add ? com_rd + VW'(1) : com_rd - VW'(1);
    end else if (pw_b && (pk != vb) && rowa[pk]) begin
      com_we = 1'b1;
      com_wa = pair_addr(vb, pk);
      com_wd = add ? com_rd + VW'(1) : com_rd - VW'(1);
    end
  end

  gefa_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_wa),
    .wdata (adj_wd),
    .raddr (adj_ra),
    .rdata (adj_rd)
  );

  gefa_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_wa),
    .wdata (deg_wd),
    .raddr (deg_ra),
    .rdata (deg_rd)
  );

  gefa_ram #(.WIDTH(VW), .DEPTH(1 << PW)) u_com_ram (
    .clk   (clk),
    .we    (com_we),
    .waddr (com_wa),
    .wdata (com_wd),
    .raddr (com_ra),
    .rdata (com_rd)
  );

  // Saturate the delta to the output field
  always_comb begin
    if (acc > SAT_HI) begin
      vc = SAT_HI[gefa_pkg::VC_W-1:0];
    end else if (acc < SAT_LO) begin
      vc = SAT_LO[gefa_pkg::VC_W-1:0];
    end else begin
      vc = acc[gefa_pkg::VC_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.ld_res) begin
      if (stat.skip) begin
        res_vc   <= '0;
        res_flip <= 1'b0;
        res_skip <= 1'b1;
        res_edge <= 1'b0;
      end else begin
        res_vc   <= vc;
        res_flip <= flip_r;
        res_skip <= 1'b0;
        res_edge <= was ^ flip_r;
      end
    end
  end

  assign res_data = {2'b00, res_edge, res_skip, res_flip, res_vc};

endmodule

[sv/gefa_ctrl.sv]
// Controller: sequences clearing, delta walk, flip decision and count update.
module gefa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  gefa_pkg::stat_t stat,
  output gefa_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD0,
    S_RD1,
    S_CAP,
    S_PAIR,
    S_DA,
    S_DB,
    S_DDRAIN,
    S_DECIDE,
    S_UA,
    S_UB,
    S_UDRAIN,
    S_WRA,
    S_WRB,
    S_OUT
  } state_t;

  state_t state;
  logic   report;

  assign s_tready = (state == S_IDLE) && !cfg_wr_en;

  // Issue datapath operations
  always_comb begin
    cmd.op     = gefa_pkg::OP_IDLE;
    cmd.ld_res = 1'b0;
    case (state)
      S_CLEAR:  cmd.op = gefa_pkg::OP_CLEAR;
      S_IDLE:   if (s_tvalid && s_tready) begin
        cmd.op = gefa_pkg::OP_LATCH;
      end
      S_RD0:    cmd.op = gefa_pkg::OP_RD0;
      S_RD1:    cmd.op = gefa_pkg::OP_RD1;
      S_CAP:    cmd.op = gefa_pkg::OP_CAP;
      S_PAIR:   cmd.op = gefa_pkg::OP_PAIR;
      S_DA:     cmd.op = gefa_pkg::OP_DA;
      S_DB:     cmd.op = gefa_pkg::OP_DB;
      S_DECIDE: cmd.op = gefa_pkg::OP_DECIDE;
      S_UA:     cmd.op = gefa_pkg::OP_UA;
      S_UB:     cmd.op = gefa_pkg::OP_UB;
      S_WRA:    cmd.op = gefa_pkg::OP_WRA;
      S_WRB:    cmd.op = gefa_pkg::OP_WRB;
      S_OUT:    cmd.ld_res = !m_tvalid || m_tready;
      default:  cmd.op = gefa_pkg::OP_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      report   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.ld_res) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: if (stat.clr_last) begin
          state <= report ? S_OUT : S_IDLE;
        end
        S_IDLE: begin
          if (cfg_wr_en) begin
            state  <= S_CLEAR;
            report <= 1'b0;
          end else if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.is_clear) begin
            state  <= S_CLEAR;
            report <= 1'b1;
          end else if (stat.skip) begin
            state <= S_OUT;
          end else begin
            state <= S_RD0;
          end
        end
        S_RD0:    state <= S_RD1;
        S_RD1:    state <= S_CAP;
        S_CAP:    state <= S_PAIR;
        S_PAIR:   state <= S_DA;
        S_DA:     state <= S_DB;
        S_DB:     state <= stat.k_last ? S_DDRAIN : S_DA;
        S_DDRAIN: state <= S_DECIDE;
        S_DECIDE: state <= stat.flip ? S_UA : S_OUT;
        S_UA:     state <= S_UB;
        S_UB:     state <= stat.k_last ? S_UDRAIN : S_UA;
        S_UDRAIN: state <= S_WRA;
        S_WRA:    state <= S_WRB;
        S_WRB:    state <= S_OUT;
        S_OUT: if (cmd.ld_res) begin
          state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/graph_edge_flip_annealer.sv]
// Edge-flip annealer over a book-graph candidate, one transaction in flight at a time.
// A skipped pair goes straight to the result; an anneal or force request walks every vertex
// to sum the delta and, on a flip, walks them again to update counts (V = 4n-2 vertices), over one count-RAM port.
// Clear request or book_size write: a sweep over all (2**clog2(MAX_VERTICES))**2 count-RAM entries.
// Reset (rst, synchronous) starts the same sweep; s_tready stays low until it ends.
module graph_edge_flip_annealer #(
  parameter int MAX_VERTICES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,  // book_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,      // vertex_a, vertex_b, accept_roll, accept_threshold
  input  logic [1:0]  s_tuser,      // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata       // violation_change, flip_done, pair_skipped, edge_present
);

  gefa_pkg::cmd_t  cmd;
  gefa_pkg::stat_t stat;

  gefa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gefa_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_tdata),
    .in_user     (s_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .res_data    (m_tdata)
  );

endmodule
